@@ hw/rtl/r2p_pkg.sv @@
// Shared constants, types and the arctangent table of the rectangular-to-polar block.
// No dependencies; every other file of the block but r2p_sqrt_cell uses it by scoped names.
package r2p_pkg;

  // defaults of the top-level parameters
  localparam int unsigned COORD_WIDTH_DEF  = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // result field widths
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned ANG_W  = 16;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned OUT_DW = ((MAG_W + ANG_W + CODE_W + 7) / 8) * 8;

  // angle accumulator: degrees scaled by 2^24, signed
  localparam int unsigned GUARD_BITS = 24;
  localparam int unsigned Z_W        = 32;
  localparam int unsigned Z_RND_SH   = 17;
  localparam logic [Z_W-1:0] Z_DEG90 = 32'd1509949440;
  localparam logic [Z_W-1:0] Z_HALF  = 32'd65536;

  // Q9.7 angles
  localparam logic [ANG_W-1:0] Q7_DEG90  = 16'd11520;
  localparam logic [ANG_W-1:0] Q7_DEG180 = 16'd23040;
  localparam logic [ANG_W-1:0] Q7_DEG270 = 16'd34560;
  localparam logic [ANG_W-1:0] Q7_DEG360 = 16'd46080;

  typedef enum logic [CODE_W-1:0] {
    LocOrigin = 3'd0,
    LocYAxis  = 3'd1,
    LocXAxis  = 3'd2,
    LocQuad1  = 3'd3,
    LocQuad2  = 3'd4,
    LocQuad3  = 3'd5,
    LocQuad4  = 3'd6
  } loc_e;

  // round(atan(2^-i) * 180/pi * 2^24)
  function automatic logic [Z_W-1:0] atan_deg24(input logic [4:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 32'd754974720;
      5'd1:  v = 32'd445687602;
      5'd2:  v = 32'd235489088;
      5'd3:  v = 32'd119537938;
      5'd4:  v = 32'd60000934;
      5'd5:  v = 32'd30029717;
      5'd6:  v = 32'd15018523;
      5'd7:  v = 32'd7509720;
      5'd8:  v = 32'd3754917;
      5'd9:  v = 32'd1877466;
      5'd10: v = 32'd938734;
      5'd11: v = 32'd469367;
      5'd12: v = 32'd234684;
      5'd13: v = 32'd117342;
      5'd14: v = 32'd58671;
      5'd15: v = 32'd29335;
      5'd16: v = 32'd14668;
      5'd17: v = 32'd7334;
      5'd18: v = 32'd3667;
      5'd19: v = 32'd1833;
      5'd20: v = 32'd917;
      5'd21: v = 32'd458;
      5'd22: v = 32'd229;
      5'd23: v = 32'd115;
      5'd24: v = 32'd57;
      5'd25: v = 32'd29;
      5'd26: v = 32'd14;
      5'd27: v = 32'd7;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      5'd30: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/r2p_cordic_cell.sv @@
// One CORDIC vectoring cell: a fixed-shift micro-rotation on (x, y) and the angle update.
// Depends on r2p_pkg for the accumulator width and the arctangent table.
module r2p_cordic_cell #(
  parameter int unsigned XWidth = 42,
  parameter int unsigned Iter   = 0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [XWidth-1:0]      cx_i,
  input  logic signed [XWidth-1:0]      cy_i,
  input  logic signed [r2p_pkg::Z_W-1:0] z_i,
  output logic signed [XWidth-1:0]      cx_o,
  output logic signed [XWidth-1:0]      cy_o,
  output logic signed [r2p_pkg::Z_W-1:0] z_o
);

  localparam logic signed [r2p_pkg::Z_W-1:0] Atan = r2p_pkg::atan_deg24(5'(Iter));

  logic signed [XWidth-1:0]       dx, dy;
  logic signed [XWidth-1:0]       cx_d, cy_d, cx_q, cy_q;
  logic signed [r2p_pkg::Z_W-1:0] z_d, z_q;

  // arithmetic shift rounds toward minus infinity
  assign dx = cy_i >>> Iter;
  assign dy = cx_i >>> Iter;

  always_comb begin
    if (!cy_i[XWidth-1]) begin
      cx_d = cx_i + dx;
      cy_d = cy_i - dy;
      z_d  = z_i + Atan;
    end else begin
      cx_d = cx_i - dx;
      cy_d = cy_i + dy;
      z_d  = z_i - Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      z_q  <= z_d;
    end
  end

  assign cx_o = cx_q;
  assign cy_o = cy_q;
  assign z_o  = z_q;

endmodule

@@ hw/rtl/r2p_sqrt_cell.sv @@
// One restoring square-root cell: settles one root bit per cycle while en_i is high.
// No package dependency; widths come from the parameters.
module r2p_sqrt_cell #(
  parameter int unsigned SumWidth = 32,
  parameter int unsigned Pos      = 0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [SumWidth-1:0] rem_i,
  input  logic [SumWidth-1:0] root_i,
  output logic [SumWidth-1:0] rem_o,
  output logic [SumWidth-1:0] root_o
);

  localparam logic [SumWidth:0] Bit = (SumWidth + 1)'(1) << (2 * Pos);

  logic [SumWidth:0]   trial;
  logic                take;
  logic [SumWidth-1:0] rem_d, root_d, rem_q, root_q;

  assign trial = {1'b0, root_i} + Bit;
  assign take  = ({1'b0, rem_i} >= trial);

  always_comb begin
    if (take) begin
      rem_d  = rem_i - trial[SumWidth-1:0];
      root_d = (root_i >> 1) + Bit[SumWidth-1:0];
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

@@ hw/rtl/rect_to_polar_with_quadrant_top.sv @@
// Top level of the rectangular-to-polar converter: input stage, square-root and CORDIC rows,
// output mapping and a two-entry output buffer. Depends on r2p_pkg, r2p_sqrt_cell, r2p_cordic_cell.

// Takes one point (x, y) per cycle while s_axis_tready is high, and returns its rounded radius,
// its angle in Q9.7 degrees and a location code. The block is a pipeline of
// D = max(COORD_WIDTH + 2, CORDIC_STEPS) stages behind an input register: the square-root row
// settles one root bit per cell after a squaring and a summing stage, the CORDIC row does one
// micro-rotation per cell, and the shorter row is padded to the longer. A result leaves the
// last stage into a two-entry output buffer, which lets the pipeline keep taking points while
// a result waits; s_axis_tready drops only when both buffer entries are occupied, and the
// whole pipeline then stalls.
module rect_to_polar_with_quadrant_top #(
  parameter int unsigned COORD_WIDTH  = r2p_pkg::COORD_WIDTH_DEF,
  parameter int unsigned CORDIC_STEPS = r2p_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // x_coord, y_coord
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // magnitude, angle_deg, location_code
  output logic [r2p_pkg::OUT_DW-1:0]            m_axis_tdata
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned SW    = 2 * COORD_WIDTH;
  localparam int unsigned XW    = COORD_WIDTH + r2p_pkg::GUARD_BITS + 2;
  localparam int unsigned ZW    = r2p_pkg::Z_W;
  localparam int unsigned SQ_D  = COORD_WIDTH + 2;
  localparam int unsigned DEPTH = (SQ_D > CORDIC_STEPS) ? SQ_D : CORDIC_STEPS;
  localparam int unsigned PAD_S = DEPTH - SQ_D;
  localparam int unsigned PAD_C = DEPTH - CORDIC_STEPS;
  localparam int unsigned MW    = r2p_pkg::MAG_W;
  localparam int unsigned AW    = r2p_pkg::ANG_W;
  localparam int unsigned RES_W = r2p_pkg::MAG_W + r2p_pkg::ANG_W + r2p_pkg::CODE_W;

  typedef struct packed {
    r2p_pkg::loc_e loc;
    logic          neg;   // sign of the nonzero coordinate on an axis
  } side_t;

  logic [1:0] cnt_q, cnt_d;
  logic       en;
  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;

  // ---------------- input stage ----------------
  logic signed [CW-1:0] x_in, y_in;
  logic [CW-1:0]        ax_d, ay_d, ax_q, ay_q;
  side_t                side_d;
  side_t                side_q [DEPTH+1];
  logic [DEPTH:0]       v_q;

  assign x_in = s_axis_tdata[CW-1:0];
  assign y_in = s_axis_tdata[2*CW-1:CW];
  assign ax_d = x_in[CW-1] ? CW'(-x_in) : CW'(x_in);
  assign ay_d = y_in[CW-1] ? CW'(-y_in) : CW'(y_in);

  always_comb begin
    side_d.neg = 1'b0;
    if (x_in == '0 && y_in == '0) begin
      side_d.loc = r2p_pkg::LocOrigin;
    end else if (x_in == '0) begin
      side_d.loc = r2p_pkg::LocYAxis;
      side_d.neg = y_in[CW-1];
    end else if (y_in == '0) begin
      side_d.loc = r2p_pkg::LocXAxis;
      side_d.neg = x_in[CW-1];
    end else if (!x_in[CW-1] && !y_in[CW-1]) begin
      side_d.loc = r2p_pkg::LocQuad1;
    end else if (!y_in[CW-1]) begin
      side_d.loc = r2p_pkg::LocQuad2;
    end else if (x_in[CW-1]) begin
      side_d.loc = r2p_pkg::LocQuad3;
    end else begin
      side_d.loc = r2p_pkg::LocQuad4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[DEPTH-1:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q      <= ax_d;
      ay_q      <= ay_d;
      side_q[0] <= side_d;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[g+1] <= side_q[g];
      end
    end
  end

  // ---------------- square-root row ----------------
  logic [SW-1:0] sqx_q, sqy_q, sum_q;
  logic [SW-1:0] rem_c  [CW+1];
  logic [SW-1:0] root_c [CW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= SW'(ax_q) * SW'(ax_q);
      sqy_q <= SW'(ay_q) * SW'(ay_q);
      sum_q <= sqx_q + sqy_q;
    end
  end

  assign rem_c[0]  = sum_q;
  assign root_c[0] = '0;

  for (genvar j = 0; j < CW; j++) begin : g_sqrt
    r2p_sqrt_cell #(
      .SumWidth (SW),
      .Pos      (CW - 1 - j)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem_c[j]),
      .root_i (root_c[j]),
      .rem_o  (rem_c[j+1]),
      .root_o (root_c[j+1])
    );
  end

  logic [SW-1:0] rem_p  [PAD_S+1];
  logic [SW-1:0] root_p [PAD_S+1];
  assign rem_p[0]  = rem_c[CW];
  assign root_p[0] = root_c[CW];

  for (genvar p = 0; p < PAD_S; p++) begin : g_pad_s
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_p[p+1]  <= rem_p[p];
        root_p[p+1] <= root_p[p];
      end
    end
  end

  // ---------------- CORDIC row ----------------
  logic signed [XW-1:0] cx_c [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy_c [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_c  [CORDIC_STEPS+1];

  assign cx_c[0] = $signed({2'b00, ax_q, {r2p_pkg::GUARD_BITS{1'b0}}});
  assign cy_c[0] = $signed({2'b00, ay_q, {r2p_pkg::GUARD_BITS{1'b0}}});
  assign z_c[0]  = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    r2p_cordic_cell #(
      .XWidth (XW),
      .Iter   (i)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .cx_i  (cx_c[i]),
      .cy_i  (cy_c[i]),
      .z_i   (z_c[i]),
      .cx_o  (cx_c[i+1]),
      .cy_o  (cy_c[i+1]),
      .z_o   (z_c[i+1])
    );
  end

  logic signed [ZW-1:0] z_p [PAD_C+1];
  assign z_p[0] = z_c[CORDIC_STEPS];

  for (genvar p = 0; p < PAD_C; p++) begin : g_pad_c
    always_ff @(posedge clk_i) begin
      if (en) begin
        z_p[p+1] <= z_p[p];
      end
    end
  end

  // ---------------- output mapping ----------------
  logic [CW:0]    root_rnd;
  logic [MW-1:0]  mag;
  logic [ZW-1:0]  z_clamp, z_rnd;
  logic [AW-1:0]  ang_a, ang;
  side_t          side_o;

  assign side_o   = side_q[DEPTH];
  assign root_rnd = {1'b0, root_p[PAD_S][CW-1:0]}
                  + (CW + 1)'(rem_p[PAD_S] > root_p[PAD_S]);

  if (CW + 1 > MW) begin : g_sat
    assign mag = (|root_rnd[CW:MW]) ? '1 : root_rnd[MW-1:0];
  end else begin : g_nosat
    assign mag = MW'(root_rnd);
  end

  always_comb begin
    if (z_p[PAD_C][ZW-1]) begin
      z_clamp = '0;
    end else if ($unsigned(z_p[PAD_C]) > r2p_pkg::Z_DEG90) begin
      z_clamp = r2p_pkg::Z_DEG90;
    end else begin
      z_clamp = $unsigned(z_p[PAD_C]);
    end
  end

  assign z_rnd = (z_clamp + r2p_pkg::Z_HALF) >> r2p_pkg::Z_RND_SH;
  assign ang_a = z_rnd[AW-1:0];

  always_comb begin
    case (side_o.loc)
      r2p_pkg::LocOrigin: ang = '0;
      r2p_pkg::LocYAxis:  ang = side_o.neg ? r2p_pkg::Q7_DEG270 : r2p_pkg::Q7_DEG90;
      r2p_pkg::LocXAxis:  ang = side_o.neg ? r2p_pkg::Q7_DEG180 : '0;
      r2p_pkg::LocQuad1:  ang = ang_a;
      r2p_pkg::LocQuad2:  ang = r2p_pkg::Q7_DEG180 - ang_a;
      r2p_pkg::LocQuad3:  ang = r2p_pkg::Q7_DEG180 + ang_a;
      r2p_pkg::LocQuad4:  ang = (ang_a == '0) ? '0 : r2p_pkg::Q7_DEG360 - ang_a;
      default:            ang = '0;
    endcase
  end

  // ---------------- output buffer ----------------
  logic [RES_W-1:0] res;
  logic [RES_W-1:0] buf_q [2];
  logic             wr_q, rd_q;
  logic             push, pop;

  assign res  = {side_o.loc, ang, mag};
  assign push = v_q[DEPTH] && en;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= res;
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = r2p_pkg::OUT_DW'(buf_q[rd_q]);

endmodule

@@ hw/rtl/r2p_checker.sv @@
// Port-level checks of the rectangular-to-polar block, bound to its top level.
// Depends on r2p_pkg for the result layout, location codes and angle constants.
module r2p_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [r2p_pkg::OUT_DW-1:0] m_axis_tdata
);

  logic [r2p_pkg::MAG_W-1:0]  mag;
  logic [r2p_pkg::ANG_W-1:0]  ang;
  logic [r2p_pkg::CODE_W-1:0] loc;

  assign mag = m_axis_tdata[r2p_pkg::MAG_W-1:0];
  assign ang = m_axis_tdata[r2p_pkg::MAG_W +: r2p_pkg::ANG_W];
  assign loc = m_axis_tdata[r2p_pkg::MAG_W + r2p_pkg::ANG_W +: r2p_pkg::CODE_W];

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && loc == r2p_pkg::LocOrigin |-> mag == '0 && ang == '0)
    else $error("origin result not zero");

  a_xaxis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && loc == r2p_pkg::LocXAxis |->
      ang == '0 || ang == r2p_pkg::Q7_DEG180)
    else $error("x axis angle off");

  a_quad1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && loc == r2p_pkg::LocQuad1 |-> ang <= r2p_pkg::Q7_DEG90 && mag != '0)
    else $error("first quadrant result out of range");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ang < r2p_pkg::Q7_DEG360)
    else $error("angle not below 360 degrees");

endmodule

bind rect_to_polar_with_quadrant_top r2p_checker u_r2p_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ verif/tb_rect_to_polar_with_quadrant_top.sv @@
// Self-checking testbench for rect_to_polar_with_quadrant_top: drives points on the input
// stream and checks radius, angle and location code against a built-in CORDIC predictor.
// Depends on r2p_pkg and the block's RTL.
module tb_rect_to_polar_with_quadrant_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_W   = r2p_pkg::COORD_WIDTH_DEF;
  localparam int unsigned ITERS     = (r2p_pkg::CORDIC_STEPS_DEF > 32) ? 32
                                    : r2p_pkg::CORDIC_STEPS_DEF;
  localparam int unsigned IN_DW     = ((2 * COORD_W + 7) / 8) * 8;
  localparam int unsigned LATENCY   = COORD_W + 2 + 2;
  localparam int unsigned MAX_CYCLES = 400000;
  localparam int unsigned MAG_W     = r2p_pkg::MAG_W;
  localparam int unsigned ANG_W     = r2p_pkg::ANG_W;
  localparam int unsigned CODE_W    = r2p_pkg::CODE_W;

  // atan(2^-i) in degrees scaled by 2^24
  localparam longint ATAN_TBL [32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2,
    1, 0
  };

  typedef struct packed {
    r2p_pkg::loc_e    loc;
    logic [ANG_W-1:0] ang;
    logic [MAG_W-1:0] mag;
  } polar_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [IN_DW-1:0]           s_axis_tdata;   // x_coord, y_coord
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [r2p_pkg::OUT_DW-1:0] m_axis_tdata;   // magnitude, angle_deg, location_code

  polar_t      polar_q[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  rect_to_polar_with_quadrant_top i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor

  // rounded square root: round up when the remainder exceeds the floor root
  function automatic logic [MAG_W-1:0] round_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    if (v - r * r > r) r++;
    if (r > 65535) r = 65535;
    return r[MAG_W-1:0];
  endfunction

  // vectoring CORDIC on |x|, |y|; result in Q9.7 degrees within 0..90
  function automatic logic [ANG_W-1:0] quad1_angle(input longint ax, input longint ay);
    longint cx;
    longint cy;
    longint z;
    longint dx;
    longint dy;
    longint zr;
    cx = ax <<< r2p_pkg::GUARD_BITS;
    cy = ay <<< r2p_pkg::GUARD_BITS;
    z  = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx;
        cy -= dy;
        z  += ATAN_TBL[i];
      end else begin
        cx -= dx;
        cy += dy;
        z  -= ATAN_TBL[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) <<< 24)) z = longint'(90) <<< 24;
    zr = (z + 65536) >>> 17;
    return zr[ANG_W-1:0];
  endfunction

  function automatic polar_t predict_polar(input logic signed [COORD_W-1:0] x,
                                           input logic signed [COORD_W-1:0] y);
    polar_t p;
    longint ax;
    longint ay;
    int     a;
    int     ang;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    p.mag = round_root(longint'(ax * ax + ay * ay));
    ang = 0;
    if (x == 0 && y == 0) begin
      p.loc = r2p_pkg::LocOrigin;
    end else if (x == 0) begin
      p.loc = r2p_pkg::LocYAxis;
      ang   = (y > 0) ? int'(r2p_pkg::Q7_DEG90) : int'(r2p_pkg::Q7_DEG270);
    end else if (y == 0) begin
      p.loc = r2p_pkg::LocXAxis;
      ang   = (x > 0) ? 0 : int'(r2p_pkg::Q7_DEG180);
    end else begin
      a = int'(quad1_angle(ax, ay));
      if (x > 0 && y > 0) begin
        p.loc = r2p_pkg::LocQuad1;
        ang   = a;
      end else if (x < 0 && y > 0) begin
        p.loc = r2p_pkg::LocQuad2;
        ang   = int'(r2p_pkg::Q7_DEG180) - a;
      end else if (x < 0) begin
        p.loc = r2p_pkg::LocQuad3;
        ang   = int'(r2p_pkg::Q7_DEG180) + a;
      end else begin
        p.loc = r2p_pkg::LocQuad4;
        ang   = int'(r2p_pkg::Q7_DEG360) - a;
      end
      if (ang >= int'(r2p_pkg::Q7_DEG360)) ang = 0;
    end
    p.ang = ang[ANG_W-1:0];
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // checking

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    polar_t got;
    polar_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        polar_q.push_back(predict_polar(s_axis_tdata[COORD_W-1:0],
                                        s_axis_tdata[2*COORD_W-1:COORD_W]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = polar_t'(m_axis_tdata[MAG_W+ANG_W+CODE_W-1:0]);
        if (polar_q.size() == 0) begin
          report_mismatch("unexpected item, magnitude", int'(got.mag), -1);
        end else begin
          want = polar_q.pop_front();
          if (got.mag !== want.mag) report_mismatch("magnitude", int'(got.mag), int'(want.mag));
          if (got.ang !== want.ang) report_mismatch("angle_deg", int'(got.ang), int'(want.ang));
          if (got.loc !== want.loc)
            report_mismatch("location_code", int'(got.loc), int'(want.loc));
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus

  // returns in the time step of the accepting edge with tvalid still high
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DW - 2 * COORD_W){1'b0}}, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // the first edge lets the monitor record an item accepted in this time step
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (polar_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord();
    int unsigned sel;
    logic signed [COORD_W-1:0] v;
    sel = $urandom_range(99);
    if (sel < 55) begin
      v = COORD_W'($urandom);
    end else if (sel < 75) begin
      v = COORD_W'($urandom_range(32)) - COORD_W'(16);
    end else if (sel < 85) begin
      case ($urandom_range(5))
        0: v = {1'b1, {(COORD_W-1){1'b0}}};
        1: v = {1'b0, {(COORD_W-1){1'b1}}};
        2: v = {1'b1, {(COORD_W-2){1'b0}}, 1'b1};
        3: v = '0;
        4: v = COORD_W'(1);
        default: v = '1;
      endcase
    end else begin
      v = COORD_W'($urandom_range(1 << ($urandom_range(COORD_W - 1))));
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  task automatic test_origin_and_axes();
    send_point(0, 0);
    send_point(0, 1);
    send_point(0, -1);
    send_point(0, 32767);
    send_point(0, -32768);
    send_point(1, 0);
    send_point(-1, 0);
    send_point(32767, 0);
    send_point(-32768, 0);
  endtask

  task automatic test_quadrants();
    send_point(1, 1);
    send_point(-1, 1);
    send_point(-1, -1);
    send_point(1, -1);
    send_point(3, 4);
    send_point(-3, -4);
    send_point(30000, -17321);
    // near-zero angle in quadrant four wraps from 360 to 0
    send_point(32767, -1);
  endtask

  task automatic test_extremes();
    send_point(32767, 32767);
    send_point(-32768, -32768);
    send_point(-32768, 32767);
    send_point(32767, -32768);
    send_point(1, 32767);
    send_point(-32768, 1);
    send_point(1, -32768);
  endtask

  task automatic test_random_points(input int unsigned count, input int unsigned src_pct,
                                    input int unsigned snk_pct);
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int unsigned n = 0; n < count; n++) begin
      x = pick_coord();
      y = pick_coord();
      // diagonals hit the 45 degree points of each quadrant
      if ($urandom_range(15) == 0) y = $urandom_range(1) ? x : -x;
      send_point(x, y);
    end
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_origin_and_axes();
    test_quadrants();
    test_extremes();
    wait_drained();

    test_random_points(300, 0, 0);
    test_random_points(250, 86, 0);
    test_random_points(250, 0, 86);
    test_random_points(200, 9, 9);

    repeat (2 * LATENCY) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
